/* rtl/tpd_pkg.sv */
package tpd_pkg;

    localparam int LEVEL_W  = 8;
    localparam int DELAY_W  = 20;
    localparam int CFG_W    = 16;
    localparam int AMOUNT_W = 11;
    localparam int ACTION_W = 3;
    localparam int CFG_IDX_W = 2;

    localparam int MAX_LEVEL    = 255;
    localparam int TOGGLE_LEVEL = 25;

    // floor(x / MAX_LEVEL) == (x * RECIP) >> RECIP_SHIFT for every x below 2^24
    localparam int RECIP_SHIFT = 32;
    localparam int RECIP_W     = 29;
    localparam longint unsigned RECIP_L =
        ((64'd1 << RECIP_SHIFT) + 64'(MAX_LEVEL) - 64'd1) / 64'(MAX_LEVEL);
    localparam logic [RECIP_W-1:0] RECIP = RECIP_W'(RECIP_L);
    localparam int SCALE_W = CFG_W + RECIP_W;
    localparam int PROD_W  = SCALE_W + LEVEL_W;

    localparam logic [CFG_W-1:0]   MIN_DELAY_RST = 16'd100;
    localparam logic [CFG_W-1:0]   SPAN_RST      = 16'd7500;
    localparam logic [CFG_W-1:0]   THRESH_RST    = 16'd4000;
    localparam logic [SCALE_W-1:0] SPAN_SCALED_RST = SCALE_W'(SPAN_RST) * SCALE_W'(RECIP);
    localparam logic [DELAY_W-1:0] FIRE_DELAY_RST = 20'd1000000;
    localparam logic [LEVEL_W-1:0] LEVEL_FULL = LEVEL_W'(MAX_LEVEL);

    localparam logic [ACTION_W-1:0] ACT_SET    = 3'd0;
    localparam logic [ACTION_W-1:0] ACT_INC    = 3'd1;
    localparam logic [ACTION_W-1:0] ACT_DEC    = 3'd2;
    localparam logic [ACTION_W-1:0] ACT_TOGGLE = 3'd3;
    localparam logic [ACTION_W-1:0] ACT_ZCROSS = 3'd4;
    localparam logic [ACTION_W-1:0] ACT_TICK   = 3'd5;

    localparam logic [CFG_IDX_W-1:0] CFG_MIN_DELAY = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SPAN      = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_THRESH    = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_NEUTRAL   = 2'd3;

    typedef struct packed {
        logic [CFG_W-1:0]   min_delay;
        logic [SCALE_W-1:0] span_scaled;
        logic [CFG_W-1:0]   thresh;
        logic               neutral_wired;
    } tpd_cfg_t;

    typedef struct packed {
        logic [LEVEL_W-1:0] level;
        logic [DELAY_W-1:0] fire_delay;
        logic               zc_seen;
        logic               timer_running;
        logic [DELAY_W-1:0] tick_count;
        logic               gate;
    } tpd_state_t;

endpackage

/* rtl/triac_phase_dimmer_unit.sv */
// an accepted item is held in the input register, and its result then in the result register
// throughput: one item per cycle unless the output is held; the level, delay and timer state loop closes through st_reg
// the firing delay product uses a per-span reciprocal scale computed when span is written
// s_axis_tready drops only while both the input and the result register are held
// rst_n is asynchronous active low: level full, gate on, delay 1000000 us, timer stopped
module triac_phase_dimmer_unit import tpd_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    input  logic [15:0]           s_axis_tdata,   // [10:0] amount
    input  logic [ACTION_W-1:0]   s_axis_tuser,   // [2:0] action
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    output logic [31:0]           m_axis_tdata,   // [0] triac_gate, [8:1] brightness, [28:9] delay_us
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_W-1:0]      cfg_data
);

    logic                 in_valid_reg;
    logic [ACTION_W-1:0]  in_action_reg;
    logic [AMOUNT_W-1:0]  in_amount_reg;
    logic                 out_valid_reg;
    logic                 out_gate_reg;
    logic [LEVEL_W-1:0]   out_level_reg;
    logic [DELAY_W-1:0]   out_delay_reg;

    logic [CFG_W-1:0]     min_delay_reg;
    logic [SCALE_W-1:0]   span_scaled_reg;
    logic [CFG_W-1:0]     thresh_reg;
    logic                 neutral_reg;

    tpd_cfg_t             cfg;
    tpd_state_t           st_reg;
    tpd_state_t           st_next;
    logic                 advance;
    logic                 in_take;

    assign advance       = in_valid_reg && (!out_valid_reg || m_axis_tready);
    assign s_axis_tready = !in_valid_reg || advance;
    assign in_take       = s_axis_tvalid && s_axis_tready;
    assign cfg_ready     = 1'b1;

    assign cfg.min_delay     = min_delay_reg;
    assign cfg.span_scaled   = span_scaled_reg;
    assign cfg.thresh        = thresh_reg;
    assign cfg.neutral_wired = neutral_reg;

    tpd_step u_step
    (
        .action (in_action_reg),
        .amount ($signed(in_amount_reg)),
        .cfg    (cfg),
        .cur    (st_reg),
        .nxt    (st_next)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            min_delay_reg   <= MIN_DELAY_RST;
            span_scaled_reg <= SPAN_SCALED_RST;
            thresh_reg      <= THRESH_RST;
            neutral_reg     <= 1'b1;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                CFG_MIN_DELAY: min_delay_reg <= cfg_data;
                CFG_SPAN:      span_scaled_reg <= SCALE_W'(cfg_data) * SCALE_W'(RECIP);
                CFG_THRESH:    thresh_reg <= cfg_data;
                CFG_NEUTRAL:   neutral_reg <= cfg_data[0];
                default:       neutral_reg <= neutral_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg        <= 1'b0;
            out_valid_reg       <= 1'b0;
            st_reg.level        <= LEVEL_FULL;
            st_reg.fire_delay   <= FIRE_DELAY_RST;
            st_reg.zc_seen      <= 1'b0;
            st_reg.timer_running <= 1'b0;
            st_reg.tick_count   <= '0;
            st_reg.gate         <= 1'b1;
        end
        else
        begin
            if (s_axis_tready)
                in_valid_reg <= s_axis_tvalid;
            if (advance)
            begin
                out_valid_reg <= 1'b1;
                st_reg        <= st_next;
            end
            else if (m_axis_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            in_action_reg <= s_axis_tuser;
            in_amount_reg <= s_axis_tdata[AMOUNT_W-1:0];
        end
        if (advance)
        begin
            out_gate_reg  <= st_next.gate;
            out_level_reg <= st_next.level;
            out_delay_reg <= st_next.fire_delay;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {3'b000, out_delay_reg, out_level_reg, out_gate_reg};

endmodule

/* rtl/tpd_step.sv */
module tpd_step import tpd_pkg::*;
(
    input  logic [ACTION_W-1:0]        action,
    input  logic signed [AMOUNT_W-1:0] amount,
    input  tpd_cfg_t                   cfg,
    input  tpd_state_t                 cur,
    output tpd_state_t                 nxt
);

    logic signed [AMOUNT_W:0] amount_ext;
    logic signed [AMOUNT_W:0] level_ext;
    logic signed [AMOUNT_W:0] req;
    logic                     do_level;
    logic [LEVEL_W-1:0]       lvl;
    logic [LEVEL_W-1:0]       dim;
    logic [PROD_W-1:0]        prod;
    logic [CFG_W-1:0]         quo;
    logic [CFG_W:0]           dly;
    logic [DELAY_W-1:0]       cnt;

    assign amount_ext = {amount[AMOUNT_W-1], amount};
    assign level_ext  = $signed({{(AMOUNT_W + 1 - LEVEL_W){1'b0}}, cur.level});

    always_comb
    begin
        req      = '0;
        do_level = 1'b0;
        case (action)
            ACT_SET:
            begin
                req      = amount_ext;
                do_level = 1'b1;
            end
            ACT_INC:
            begin
                req      = level_ext + amount_ext;
                do_level = 1'b1;
            end
            ACT_DEC:
            begin
                req      = level_ext - amount_ext;
                do_level = 1'b1;
            end
            ACT_TOGGLE:
            begin
                req      = (cur.level > LEVEL_W'(TOGGLE_LEVEL)) ? '0
                                                               : (AMOUNT_W + 1)'(MAX_LEVEL);
                do_level = 1'b1;
            end
            default:
            begin
                req      = '0;
                do_level = 1'b0;
            end
        endcase

        if (req > $signed((AMOUNT_W + 1)'(MAX_LEVEL)))
            lvl = LEVEL_FULL;
        else if (req < 0)
            lvl = '0;
        else
            lvl = req[LEVEL_W-1:0];
    end

    // span * dim / MAX_LEVEL via the reciprocal already folded into span_scaled
    assign dim  = LEVEL_FULL - lvl;
    assign prod = PROD_W'(cfg.span_scaled) * PROD_W'(dim);
    assign quo  = prod[RECIP_SHIFT +: CFG_W];
    assign dly  = {1'b0, cfg.min_delay} + {1'b0, quo};
    assign cnt  = cur.tick_count + DELAY_W'(1);

    always_comb
    begin
        nxt = cur;
        if (do_level)
        begin
            if (!cfg.neutral_wired)
            begin
                if (cur.fire_delay < DELAY_W'(cfg.thresh))
                    nxt.zc_seen = 1'b0;
                else if (!cur.zc_seen)
                    nxt.gate = 1'b0;
            end
            if (lvl != '0 && lvl != LEVEL_FULL)
                nxt.fire_delay = DELAY_W'(dly);
            if (lvl == '0)
                nxt.gate = 1'b0;
            if (lvl == LEVEL_FULL)
                nxt.gate = 1'b1;
            nxt.level = lvl;
        end
        else if (action == ACT_ZCROSS)
        begin
            if (cur.level != LEVEL_FULL)
                nxt.gate = 1'b0;
            nxt.tick_count    = '0;
            nxt.timer_running = 1'b1;
            nxt.zc_seen       = 1'b1;
        end
        else if (action == ACT_TICK && cur.timer_running)
        begin
            // timer reloads on expiry and keeps running
            if (cnt >= cur.fire_delay)
            begin
                nxt.gate       = (cur.level != '0);
                nxt.tick_count = '0;
            end
            else
            begin
                nxt.tick_count = cnt;
            end
        end
    end

endmodule

/* rtl/tpd_checker.sv */
module tpd_checker import tpd_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  s_axis_tready,
    input  logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    input  logic [31:0]           m_axis_tdata
);

    // a held result keeps its data
    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("result changed while stalled");

    // input side only backs up behind a stalled output
    assert property (@(posedge clk) disable iff (!rst_n)
        !s_axis_tready |-> m_axis_tvalid && !m_axis_tready)
        else $error("input stalled without output backpressure");

    // level zero never drives the gate
    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tdata[8:1] == '0 |-> !m_axis_tdata[0])
        else $error("gate on at level zero");

    // full level always drives the gate
    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tdata[8:1] == LEVEL_FULL |-> m_axis_tdata[0])
        else $error("gate off at full level");

endmodule

bind triac_phase_dimmer_unit tpd_checker u_tpd_checker
(
    .clk           (clk),
    .rst_n         (rst_n),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);

/* verif/triac_phase_dimmer_unit_tb.sv */
`timescale 1ns / 100ps

module triac_phase_dimmer_unit_tb;
    import tpd_pkg::*;

    localparam logic [ACTION_W-1:0] ACT_SPARE_A = 3'd6;
    localparam logic [ACTION_W-1:0] ACT_SPARE_B = 3'd7;
    localparam int CYCLE_LIMIT = 150000;

    typedef struct packed {
        logic [ACTION_W-1:0] action;
        logic [AMOUNT_W-1:0] amount;
    } dim_cmd_t;

    typedef struct packed {
        logic               gate;
        logic [LEVEL_W-1:0] level;
        logic [DELAY_W-1:0] delay;
    } dim_obs_t;

    logic                 clk = 1'b0;
    logic                 rst_n = 1'b0;
    logic                 s_axis_tvalid = 1'b0;
    logic                 s_axis_tready;
    logic [15:0]          s_axis_tdata = '0;
    logic [ACTION_W-1:0]  s_axis_tuser = '0;
    logic                 m_axis_tvalid;
    logic                 m_axis_tready = 1'b0;
    logic [31:0]          m_axis_tdata;
    logic                 cfg_valid = 1'b0;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [CFG_W-1:0]     cfg_data = '0;

    dim_cmd_t cmd_q[$];
    dim_obs_t dim_expected_q[$];
    dim_cmd_t drv_cmd;
    dim_obs_t drv_obs;
    dim_obs_t want;
    int       src_gap = 0;
    int       src_calm = 0;
    int       snk_gap = 0;
    int       snk_calm = 0;
    bit       no_idle = 1'b0;
    int       errors = 0;
    int       cycle_count = 0;

    // predictor copy of the dimmer
    int unsigned min_m, span_m, thresh_m, neutral_m;
    int unsigned lvl_m, delay_m, zc_m, run_m, ticks_m, gate_m;

    triac_phase_dimmer_unit dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),   // [10:0] amount
        .s_axis_tuser  (s_axis_tuser),   // [2:0] action
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),   // [0] gate, [8:1] brightness, [28:9] delay_us
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    always #10 clk = ~clk;

    task automatic reset_dimmer_model();
        min_m = 100;
        span_m = 7500;
        thresh_m = 4000;
        neutral_m = 1;
        lvl_m = MAX_LEVEL;
        delay_m = 1000000;
        zc_m = 0;
        run_m = 0;
        ticks_m = 0;
        gate_m = 1;
    endtask

    task automatic change_level(input int req);
        int unsigned lvl;
        lvl = (req > MAX_LEVEL) ? MAX_LEVEL : ((req < 0) ? 0 : req);
        // without neutral the old delay decides whether the gate must wait for a zero-cross
        if (neutral_m == 0)
        begin
            if (delay_m < thresh_m)
                zc_m = 0;
            else if (zc_m == 0)
                gate_m = 0;
        end
        if (lvl > 0 && lvl < MAX_LEVEL)
            delay_m = (min_m + (span_m * (MAX_LEVEL - lvl)) / MAX_LEVEL) & 20'hFFFFF;
        if (lvl == 0)
            gate_m = 0;
        if (lvl == MAX_LEVEL)
            gate_m = 1;
        lvl_m = lvl;
    endtask

    task automatic advance_dimmer(input logic [ACTION_W-1:0] act,
                                  input logic [AMOUNT_W-1:0] amt, output dim_obs_t obs);
        int          step;
        int unsigned cnt;
        step = $signed(amt);
        case (act)
            ACT_SET:    change_level(step);
            ACT_INC:    change_level(int'(lvl_m) + step);
            ACT_DEC:    change_level(int'(lvl_m) - step);
            ACT_TOGGLE: change_level((lvl_m > TOGGLE_LEVEL) ? 0 : MAX_LEVEL);
            ACT_ZCROSS:
            begin
                if (lvl_m < MAX_LEVEL)
                    gate_m = 0;
                ticks_m = 0;
                run_m = 1;
                zc_m = 1;
            end
            ACT_TICK:
            begin
                if (run_m != 0)
                begin
                    cnt = (ticks_m + 1) & 20'hFFFFF;
                    if (cnt >= delay_m)
                    begin
                        gate_m = (lvl_m != 0);
                        cnt = 0;
                    end
                    ticks_m = cnt;
                end
            end
            default:
            begin
            end
        endcase
        obs.gate = gate_m[0];
        obs.level = lvl_m[LEVEL_W-1:0];
        obs.delay = delay_m[DELAY_W-1:0];
    endtask

    task automatic queue_cmd(input logic [ACTION_W-1:0] act, input logic [AMOUNT_W-1:0] amt);
        dim_cmd_t c;
        c.action = act;
        c.amount = amt;
        cmd_q.push_back(c);
    endtask

    function automatic logic [AMOUNT_W-1:0] pick_level();
        return ($urandom_range(0, 9) < 7) ? AMOUNT_W'($urandom_range(0, 255))
                                          : AMOUNT_W'($urandom);
    endfunction

    function automatic logic [AMOUNT_W-1:0] pick_step();
        int r;
        r = $urandom_range(0, 9);
        if (r < 5)
            return AMOUNT_W'($urandom_range(0, 40));
        else if (r < 7)
            return AMOUNT_W'(-$urandom_range(1, 40));
        return AMOUNT_W'($urandom);
    endfunction

    // mostly mains half cycles: a zero-cross then a run of ticks, level changes mixed in
    task automatic queue_random_phase(input int n);
        int k, r, t;
        k = 0;
        while (k < n)
        begin
            r = $urandom_range(0, 99);
            if (r < 14)
            begin
                queue_cmd(ACT_ZCROSS, AMOUNT_W'($urandom));
                t = $urandom_range(1, 24);
                repeat (t) queue_cmd(ACT_TICK, AMOUNT_W'($urandom));
                k += t;
            end
            else if (r < 32)
                queue_cmd(ACT_SET, pick_level());
            else if (r < 46)
                queue_cmd(ACT_INC, pick_step());
            else if (r < 60)
                queue_cmd(ACT_DEC, pick_step());
            else if (r < 66)
                queue_cmd(ACT_TOGGLE, AMOUNT_W'($urandom));
            else if (r < 69)
                queue_cmd(($urandom_range(0, 1) != 0) ? ACT_SPARE_A : ACT_SPARE_B,
                          AMOUNT_W'($urandom));
            else
                queue_cmd(ACT_TICK, AMOUNT_W'($urandom));
            k++;
        end
    endtask

    task automatic put_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
        cfg_index <= idx;
        cfg_data <= val;
        do @(posedge clk); while (!cfg_ready);
    endtask

    // only called while the dimmer is idle
    task automatic program_dimmer(input logic [CFG_W-1:0] min_d, input logic [CFG_W-1:0] span,
                                  input logic [CFG_W-1:0] thresh, input logic neutral);
        cfg_valid <= 1'b1;
        put_reg(CFG_MIN_DELAY, min_d);
        put_reg(CFG_SPAN, span);
        put_reg(CFG_THRESH, thresh);
        put_reg(CFG_NEUTRAL, {15'd0, neutral});
        cfg_valid <= 1'b0;
        min_m = min_d;
        span_m = span;
        thresh_m = thresh;
        neutral_m = neutral;
    endtask

    task automatic drain();
        do @(posedge clk);
        while (cmd_q.size() != 0 || s_axis_tvalid || dim_expected_q.size() != 0);
        repeat (6) @(posedge clk);
    endtask

    // driver
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            s_axis_tvalid <= 1'b0;
        end
        else
        begin
            if (s_axis_tvalid && s_axis_tready)
            begin
                advance_dimmer(s_axis_tuser, s_axis_tdata[AMOUNT_W-1:0], drv_obs);
                dim_expected_q.push_back(drv_obs);
            end
            if (s_axis_tvalid && !s_axis_tready)
            begin
                // item not taken yet, hold it
            end
            else if (src_gap != 0)
            begin
                src_gap--;
                s_axis_tvalid <= 1'b0;
            end
            else if (cmd_q.size() != 0 && !no_idle && src_calm == 0
                     && $urandom_range(0, 9) == 0)
            begin
                src_gap = $urandom_range(1, 16) - 1;
                src_calm = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 80) : 0;
                s_axis_tvalid <= 1'b0;
            end
            else if (cmd_q.size() != 0)
            begin
                drv_cmd = cmd_q.pop_front();
                s_axis_tuser <= drv_cmd.action;
                s_axis_tdata <= {5'd0, drv_cmd.amount};
                s_axis_tvalid <= 1'b1;
                if (src_calm != 0)
                    src_calm--;
            end
            else
            begin
                s_axis_tvalid <= 1'b0;
            end
        end
    end

    // monitor and result checker
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            m_axis_tready <= 1'b0;
        end
        else
        begin
            if (m_axis_tvalid && m_axis_tready)
            begin
                if (dim_expected_q.size() == 0)
                begin
                    $display("%0t: unexpected item, expected none, actual %h",
                             $time, m_axis_tdata);
                    errors++;
                end
                else
                begin
                    want = dim_expected_q.pop_front();
                    if (m_axis_tdata[0] !== want.gate)
                    begin
                        $display("%0t: triac_gate expected %0d actual %0d",
                                 $time, want.gate, m_axis_tdata[0]);
                        errors++;
                    end
                    if (m_axis_tdata[8:1] !== want.level)
                    begin
                        $display("%0t: brightness expected %0d actual %0d",
                                 $time, want.level, m_axis_tdata[8:1]);
                        errors++;
                    end
                    if (m_axis_tdata[28:9] !== want.delay)
                    begin
                        $display("%0t: delay_us expected %0d actual %0d",
                                 $time, want.delay, m_axis_tdata[28:9]);
                        errors++;
                    end
                end
            end
            if (snk_gap != 0)
            begin
                snk_gap--;
                m_axis_tready <= 1'b0;
            end
            else if (!no_idle && snk_calm == 0 && $urandom_range(0, 9) == 0)
            begin
                snk_gap = $urandom_range(1, 16) - 1;
                snk_calm = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 80) : 0;
                m_axis_tready <= 1'b0;
            end
            else
            begin
                m_axis_tready <= 1'b1;
                if (snk_calm != 0)
                    snk_calm--;
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("simulation failed");
            $finish;
        end
    end

    initial
    begin
        reset_dimmer_model();
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        repeat (2) @(posedge clk);

        // reset settings: level edges, clamping, toggle threshold, spare actions
        queue_cmd(ACT_TICK, 11'h7FF);
        queue_cmd(ACT_SPARE_A, 11'h2AA);
        queue_cmd(ACT_SPARE_B, 11'h555);
        queue_cmd(ACT_SET, 11'd1023);
        queue_cmd(ACT_SET, 11'h400);
        queue_cmd(ACT_SET, 11'd1);
        queue_cmd(ACT_SET, 11'd254);
        queue_cmd(ACT_SET, 11'd255);
        queue_cmd(ACT_SET, 11'd0);
        queue_cmd(ACT_INC, 11'd1023);
        queue_cmd(ACT_DEC, 11'd1023);
        queue_cmd(ACT_DEC, 11'h400);
        queue_cmd(ACT_INC, 11'h400);
        queue_cmd(ACT_TOGGLE, 11'd0);
        queue_cmd(ACT_TOGGLE, 11'd0);
        queue_cmd(ACT_SET, 11'd25);
        queue_cmd(ACT_TOGGLE, 11'd0);
        queue_cmd(ACT_SET, 11'd26);
        queue_cmd(ACT_TOGGLE, 11'd0);
        queue_cmd(ACT_SET, 11'd100);
        queue_cmd(ACT_ZCROSS, 11'd0);
        queue_cmd(ACT_TICK, 11'd0);
        queue_cmd(ACT_TICK, 11'd0);
        drain();

        // no neutral with tiny delays: threshold crossed both ways
        program_dimmer(16'd0, 16'd20, 16'd10, 1'b0);
        queue_cmd(ACT_SET, 11'd200);
        queue_cmd(ACT_SET, 11'd200);
        queue_cmd(ACT_SET, 11'd10);
        queue_cmd(ACT_SET, 11'd128);
        queue_cmd(ACT_ZCROSS, 11'd0);
        queue_cmd(ACT_SET, 11'd50);
        queue_random_phase(105);
        drain();

        program_dimmer(16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b1);
        queue_random_phase(100);
        drain();

        // zero delay fires on every tick
        program_dimmer(16'd0, 16'd0, 16'd0, 1'b0);
        queue_random_phase(100);
        drain();

        no_idle = 1'b1;
        program_dimmer(16'd3, 16'd40, 16'd20, 1'b1);
        queue_random_phase(110);
        drain();

        if (errors == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule

/* triac_phase_dimmer_unit.f */
rtl/tpd_pkg.sv
rtl/tpd_step.sv
rtl/triac_phase_dimmer_unit.sv
rtl/tpd_checker.sv
verif/triac_phase_dimmer_unit_tb.sv
